FILE: hw/rtl/qsom_pkg.sv
package qsom_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int STACK_DEPTH = 64;
  localparam int VAL_W       = 32;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int ORD_W       = 2;
  localparam int RANGE_W     = 2 * IDX_W;

  localparam logic [ORD_W-1:0] ORD_ASC  = 2'd0;
  localparam logic [ORD_W-1:0] ORD_DESC = 2'd1;
  localparam logic [ORD_W-1:0] ORD_EVEN = 2'd2;

  // One bit per datapath operation, driven by the controller.
  typedef struct packed {
    logic load;          // store the incoming value
    logic clr;           // start a new set
    logic push_all;      // push the whole set as the first range
    logic pop;           // read the top range, drop it from the stack
    logic take_range;    // latch the range bounds, read the pivot
    logic take_pivot;    // latch the pivot, start the scan at the low bound
    logic rd_j;          // read the scanned element
    logic take_a;        // latch the scanned element
    logic rd_place;      // read the element at the split position
    logic swap_wr_place; // first half of an exchange
    logic swap_wr_j;     // second half of an exchange, advance both indexes
    logic inc_place;
    logic inc_j;
    logic fin_wr_place;  // pivot goes to the split position
    logic fin_wr_hi;     // displaced element goes to the top, push left part
    logic push_right;    // push the right part
    logic emit_rd;       // read the next sorted element
    logic emit_ld;       // load the output register
  } qsom_cmd_t;

  typedef struct packed {
    logic count_lt2;
    logic sp_zero;
    logic range_bad;
    logic j_at_hi;
    logic precedes;
    logic place_at_j;
    logic out_free;
    logic emit_last;
  } qsom_stat_t;

  // True when a must come before b under the given order.
  function automatic logic goes_before(input logic [VAL_W-1:0] a,
                                       input logic [VAL_W-1:0] b,
                                       input logic [ORD_W-1:0] order);
    logic res;
    res = $signed(a) < $signed(b);
    if (order == ORD_DESC) begin
      res = $signed(b) < $signed(a);
    end else if (order == ORD_EVEN && a[0] != b[0]) begin
      res = ~a[0];
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/qsom_ram.sv
module qsom_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/qsom_ctrl.sv
module qsom_ctrl import qsom_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  input  qsom_stat_t stat,
  output qsom_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_LOAD    = 14'b00000000000001,
    S_START   = 14'b00000000000010,
    S_POP     = 14'b00000000000100,
    S_POPW    = 14'b00000000001000,
    S_PIV     = 14'b00000000010000,
    S_RDJ     = 14'b00000000100000,
    S_CMPJ    = 14'b00000001000000,
    S_SWP1    = 14'b00000010000000,
    S_SWP2    = 14'b00000100000000,
    S_FIN2    = 14'b00001000000000,
    S_FIN3    = 14'b00010000000000,
    S_PUSHR   = 14'b00100000000000,
    S_EMIT_RD = 14'b01000000000000,
    S_EMIT_LD = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        if (stat.count_lt2) begin
          state_nxt = S_EMIT_RD;
        end else begin
          cmd.push_all = 1'b1;
          state_nxt    = S_POP;
        end
      end
      S_POP: begin
        if (stat.sp_zero) begin
          state_nxt = S_EMIT_RD;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cmd.take_range = 1'b1;
        state_nxt      = stat.range_bad ? S_POP : S_PIV;
      end
      S_PIV: begin
        cmd.take_pivot = 1'b1;
        state_nxt      = S_RDJ;
      end
      S_RDJ: begin
        if (stat.j_at_hi) begin
          cmd.rd_place = 1'b1;
          state_nxt    = S_FIN2;
        end else begin
          cmd.rd_j  = 1'b1;
          state_nxt = S_CMPJ;
        end
      end
      S_CMPJ: begin
        cmd.take_a = 1'b1;
        if (stat.precedes && !stat.place_at_j) begin
          cmd.rd_place = 1'b1;
          state_nxt    = S_SWP1;
        end else begin
          cmd.inc_place = stat.precedes;
          cmd.inc_j     = 1'b1;
          state_nxt     = S_RDJ;
        end
      end
      S_SWP1: begin
        cmd.swap_wr_place = 1'b1;
        state_nxt         = S_SWP2;
      end
      S_SWP2: begin
        cmd.swap_wr_j = 1'b1;
        state_nxt     = S_RDJ;
      end
      S_FIN2: begin
        cmd.fin_wr_place = 1'b1;
        state_nxt        = S_FIN3;
      end
      S_FIN3: begin
        cmd.fin_wr_hi = 1'b1;
        state_nxt     = S_PUSHR;
      end
      S_PUSHR: begin
        cmd.push_right = 1'b1;
        state_nxt      = S_POP;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (stat.out_free) begin
          cmd.emit_ld = 1'b1;
          if (stat.emit_last) begin
            cmd.clr   = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

FILE: hw/rtl/qsom_dp.sv
module qsom_dp import qsom_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  qsom_cmd_t          cmd,
  output qsom_stat_t         stat,
  input  logic signed [31:0] in_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value_res,
  output logic               out_last_res
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] sp_r, sp_nxt;
  logic [CNT_W-1:0] sp_m1;
  logic [ORD_W-1:0] order_r;
  logic [IDX_W-1:0] lo_r, hi_r, place_r, j_r, k_r;
  logic [VAL_W-1:0] pivot_r, a_r, b_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_last_r;

  logic               el_we, el_re;
  logic [IDX_W-1:0]   el_waddr, el_raddr;
  logic [VAL_W-1:0]   el_wdata, el_rdata;
  logic               st_we, st_re;
  logic [RANGE_W-1:0] st_wdata, st_rdata;
  logic [IDX_W-1:0]   st_lo, st_hi;
  logic               full, sp_full, push_l_ok, push_r_ok;

  assign full    = (count_r == CNT_W'(MAX_ITEMS));
  assign sp_full = (sp_r == CNT_W'(STACK_DEPTH));
  assign sp_m1   = sp_r - CNT_W'(1);
  assign st_lo   = st_rdata[IDX_W-1:0];
  assign st_hi   = st_rdata[RANGE_W-1:IDX_W];

  // Left part holds at least two elements when place > lo + 1.
  assign push_l_ok = ({1'b0, place_r} > ({1'b0, lo_r} + CNT_W'(1)));
  assign push_r_ok = (({1'b0, place_r} + CNT_W'(1)) < {1'b0, hi_r});

  // Element store access
  assign el_we = (cmd.load && !full) || cmd.swap_wr_place || cmd.swap_wr_j ||
                 cmd.fin_wr_place || cmd.fin_wr_hi;

  always_comb begin
    el_waddr = hi_r;
    el_wdata = b_r;
    if (cmd.load) begin
      el_waddr = count_r[IDX_W-1:0];
      el_wdata = in_value;
    end else if (cmd.swap_wr_place) begin
      el_waddr = place_r;
      el_wdata = a_r;
    end else if (cmd.fin_wr_place) begin
      el_waddr = place_r;
      el_wdata = pivot_r;
    end else if (cmd.swap_wr_j) begin
      el_waddr = j_r;
    end
  end

  assign el_re = cmd.take_range || cmd.rd_j || cmd.rd_place || cmd.emit_rd;

  always_comb begin
    el_raddr = k_r;
    if (cmd.take_range) begin
      el_raddr = st_hi;
    end else if (cmd.rd_j) begin
      el_raddr = j_r;
    end else if (cmd.rd_place) begin
      el_raddr = place_r;
    end
  end

  qsom_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_elem_ram (
    .clk   (clk),
    .we    (el_we),
    .waddr (el_waddr),
    .wdata (el_wdata),
    .re    (el_re),
    .raddr (el_raddr),
    .rdata (el_rdata)
  );

  // Range stack: entry holds the high index above the low index.
  assign st_we = !sp_full && (cmd.push_all || (cmd.fin_wr_hi && push_l_ok) ||
                              (cmd.push_right && push_r_ok));
  assign st_re = cmd.pop;

  always_comb begin
    st_wdata = {hi_r, place_r + IDX_W'(1)};
    if (cmd.push_all) begin
      st_wdata = {IDX_W'(count_r - CNT_W'(1)), IDX_W'(0)};
    end else if (cmd.fin_wr_hi) begin
      st_wdata = {place_r - IDX_W'(1), lo_r};
    end
  end

  qsom_ram #(.WIDTH(RANGE_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (sp_r[IDX_W-1:0]),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (sp_m1[IDX_W-1:0]),
    .rdata (st_rdata)
  );

  always_comb begin
    count_nxt = count_r;
    sp_nxt    = sp_r;
    if (cmd.clr) begin
      count_nxt = '0;
      sp_nxt    = '0;
    end else begin
      if (cmd.load && !full) begin
        count_nxt = count_r + CNT_W'(1);
      end
      if (st_we) begin
        sp_nxt = sp_r + CNT_W'(1);
      end else if (cmd.pop) begin
        sp_nxt = sp_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sp_r        <= '0;
      order_r     <= ORD_ASC;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sp_r    <= sp_nxt;
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end
      if (cmd.clr) begin
        k_r <= '0;
      end else if (cmd.emit_ld) begin
        k_r <= k_r + IDX_W'(1);
      end
      if (cmd.emit_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_range) begin
      lo_r <= st_lo;
      hi_r <= st_hi;
    end
    if (cmd.take_pivot) begin
      pivot_r <= el_rdata;
      place_r <= lo_r;
      j_r     <= lo_r;
    end
    if (cmd.inc_place || cmd.swap_wr_j) begin
      place_r <= place_r + IDX_W'(1);
    end
    if (cmd.inc_j || cmd.swap_wr_j) begin
      j_r <= j_r + IDX_W'(1);
    end
    if (cmd.take_a) begin
      a_r <= el_rdata;
    end
    if (cmd.swap_wr_place || cmd.fin_wr_place) begin
      b_r <= el_rdata;
    end
    if (cmd.emit_ld) begin
      out_value_r <= el_rdata;
      out_last_r  <= stat.emit_last;
    end
  end

  assign stat.count_lt2  = (count_r < CNT_W'(2));
  assign stat.sp_zero    = (sp_r == '0);
  assign stat.range_bad  = ({1'b0, st_hi} >= count_r) || (st_lo >= st_hi);
  assign stat.j_at_hi    = (j_r == hi_r);
  assign stat.precedes   = goes_before(el_rdata, pivot_r, order_r);
  assign stat.place_at_j = (place_r == j_r);
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.emit_last  = (({1'b0, k_r} + CNT_W'(1)) == count_r);

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last_res  = out_last_r;

endmodule

FILE: hw/rtl/quicksort_with_order_modes.sv
// Sorts a set of signed 32-bit values under a selectable order.
// Input channel (in_valid/in_ready): one value per request; the request with
// in_last high closes the set. Up to 64 values are kept; further values are
// dropped, though a dropped request marked last still closes the set.
// Output channel (out_valid/out_ready): the sorted values, one per request,
// the final one flagged by out_last_res. A set always yields at least one.
// cfg_we/cfg_wdata set the order: 0 ascending, 1 descending, 2 even values
// first then odd, each ascending; 3 is ascending. The user must write the
// order only while the block is idle; the block itself does not enforce it.
// Loading accepts one value per cycle. The sort is Lomuto quicksort on a
// simple dual-port element memory with a range stack in a second memory.
// Each result is read from the registered element memory and then loaded
// into the output register.
// A stalled receiver holds the output register and pauses emission. After the
// last result is loaded the block takes the next set's requests while that
// result still waits. Reset clears the set and stack counts and selects
// ascending order; memory contents are not cleared.
module quicksort_with_order_modes import qsom_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value_res,
  output logic               out_last_res,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata
);

  qsom_cmd_t  cmd;
  qsom_stat_t stat;

  qsom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  qsom_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_value      (in_value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_res (out_value_res),
    .out_last_res  (out_last_res)
  );

endmodule

FILE: hw/rtl/qsom_chk.sv
module qsom_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value_res,
  input logic        out_last_res
);

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_res) &&
                                $stable(out_last_res))
    else $error("output changed while stalled");

  // Closing a set starts the sort, so no request is taken in the next cycle.
  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after the set was closed");

  // Only the final result of a set may still be pending while loading.
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_res |-> !in_ready)
    else $error("input ready while a set is being emitted");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind quicksort_with_order_modes qsom_chk u_chk (.*);

FILE: sim/sort_checker.sv
`timescale 1ns / 100ps

module sort_checker
  import qsom_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [VAL_W-1:0] out_value_res,
  input  logic                    out_last_res,
  input  logic                    cfg_we,
  input  logic [ORD_W-1:0]        cfg_wdata,
  output int                      fail_count,
  output int                      pending,
  output int                      sets_closed,
  output int                      values_checked
);

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } sorted_value_t;

  sorted_value_t           sorted_q[$];
  sorted_value_t           next_due;
  logic signed [VAL_W-1:0] set_store[MAX_ITEMS];
  int                      set_size;
  logic [ORD_W-1:0]        order_reg;

  // True when a belongs ahead of b under the given order; code 3 falls through
  // to plain ascending.
  function automatic logic ranks_first(input logic signed [VAL_W-1:0] a,
                                       input logic signed [VAL_W-1:0] b,
                                       input logic [ORD_W-1:0]        ord);
    if (ord == ORD_DESC) return b < a;
    if (ord == ORD_EVEN && a[0] != b[0]) return !a[0];
    return a < b;
  endfunction

  // Only equal values can tie under any order, so every correct sort yields
  // the same sequence and a plain insertion sort predicts the block exactly.
  task automatic sort_and_queue();
    logic signed [VAL_W-1:0] work[MAX_ITEMS];
    logic signed [VAL_W-1:0] key;
    int j;
    for (int i = 0; i < set_size; i++) work[i] = set_store[i];
    for (int i = 1; i < set_size; i++) begin
      key = work[i];
      j = i - 1;
      while (j >= 0 && ranks_first(key, work[j], order_reg)) begin
        work[j + 1] = work[j];
        j--;
      end
      work[j + 1] = key;
    end
    for (int i = 0; i < set_size; i++) begin
      sorted_q.push_back('{value: work[i], last: (i == set_size - 1)});
    end
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sorted_q.delete();
      set_size = 0;
      order_reg = ORD_ASC;
      fail_count = 0;
      sets_closed = 0;
      values_checked = 0;
    end else begin
      if (cfg_we) order_reg = cfg_wdata;
      if (out_valid && out_ready) begin
        values_checked++;
        if (sorted_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: value %0d last %0b",
                                    out_value_res, out_last_res));
        end else begin
          next_due = sorted_q.pop_front();
          if (out_value_res !== next_due.value || out_last_res !== next_due.last) begin
            report_mismatch($sformatf("result value %0d last %0b, expected value %0d last %0b",
                                      out_value_res, out_last_res,
                                      next_due.value, next_due.last));
          end
        end
      end
      if (in_valid && in_ready) begin
        // A full store drops the value, but a last flag still closes the set.
        if (set_size < MAX_ITEMS) begin
          set_store[set_size] = in_value;
          set_size++;
        end
        if (in_last) begin
          sort_and_queue();
          set_size = 0;
          sets_closed++;
        end
      end
    end
    pending = sorted_q.size();
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import qsom_pkg::*;

  localparam logic [ORD_W-1:0] ORD_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 40000;
  localparam int RANDOM_ITEMS = 230;

  typedef enum int {
    FILL_RANDOM,
    FILL_NARROW,
    FILL_CORNERS,
    FILL_RISING,
    FILL_FALLING
  } fill_style_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    in_last = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] out_value_res;
  logic                    out_last_res;
  logic                    cfg_we = 1'b0;
  logic [ORD_W-1:0]        cfg_wdata = '0;

  int fail_count;
  int pending;
  int sets_closed;
  int values_checked;

  int         items_sent = 0;
  int         burst_left = 0;
  int         quiet_cycles = 0;
  logic [3:0] orders_used = '0;
  logic [31:0] stall_pat = '1;
  int          stall_age = 0;

  logic signed [VAL_W-1:0] corner_vals[6] = '{32'sd5, -32'sd1, 32'sh80000000, 32'sd0,
                                              32'sh7FFFFFFF, -32'sd2};

  always #2 clk = ~clk;

  quicksort_with_order_modes dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value_res(out_value_res),
    .out_last_res (out_last_res),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  sort_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_res (out_value_res),
    .out_last_res  (out_last_res),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .sets_closed   (sets_closed),
    .values_checked(values_checked)
  );

  // Receiver stalls follow a rotating bit pattern that is redrawn now and then:
  // always ready, random, mostly ready or mostly stalled.
  always @(negedge clk) begin
    if (stall_age == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pat = '1;
        1: stall_pat = $urandom() | 32'h1;
        2: stall_pat = $urandom() | $urandom();
        default: stall_pat = ($urandom() & $urandom()) | 32'h1;
      endcase
      stall_age = $urandom_range(8, 80);
    end
    out_ready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[31:1]};
    stall_age--;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("No request moved for %0d cycles.", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Entered and left at a falling edge. Valid stays high into the next request
  // unless a gap is drawn after this one.
  task automatic send_request(input logic signed [VAL_W-1:0] v, input logic l);
    int gap;
    in_valid <= 1'b1;
    in_value <= v;
    in_last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_set(input int n, input fill_style_t style);
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] base;
    int stride;
    base = $urandom();
    stride = $urandom_range(1, 1000);
    for (int k = 0; k < n; k++) begin
      case (style)
        FILL_RANDOM:  v = $urandom();
        FILL_NARROW:  v = int'($urandom_range(0, 15)) - 8;
        FILL_CORNERS: v = corner_vals[$urandom_range(0, 5)];
        FILL_RISING:  v = base + k * stride;
        default:      v = base - k * stride;
      endcase
      send_request(v, k == n - 1);
    end
  endtask

  // The order may only change with the block idle, so wait for every result.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_order(input logic [ORD_W-1:0] ord);
    cfg_we <= 1'b1;
    cfg_wdata <= ord;
    orders_used[ord] = 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [ORD_W-1:0] dir_orders[4];
    dir_orders = '{ORD_ASC, ORD_DESC, ORD_EVEN, ORD_SPARE};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A set of one value, then the corner values under every order code.
    send_request(32'sh7FFFFFFF, 1'b1);
    foreach (dir_orders[o]) begin
      drain_results();
      write_order(dir_orders[o]);
      foreach (corner_vals[c]) send_request(corner_vals[c], c == 5);
    end

    // An overfull set: only the first 64 values are kept and sorted.
    drain_results();
    write_order(ORD_W'($urandom_range(0, 3)));
    send_set(67, fill_style_t'($urandom_range(0, 4)));

    while (items_sent < RANDOM_ITEMS - 15) begin
      drain_results();
      write_order(ORD_W'($urandom_range(0, 3)));
      repeat ($urandom_range(1, 4)) begin
        send_set($urandom_range(1, 12), fill_style_t'($urandom_range(0, 4)));
      end
    end
    drain_results();

    $display("Checked %0d sorted values from %0d sets (%0d requests sent).",
             values_checked, sets_closed, items_sent);
    $display("Order codes written: %b; sets ranged from one value to an overfull store.",
             orders_used);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d expected values still outstanding.", fail_count, pending);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
